// ----- rtl/assert_macros.svh -----
// assertion macros shared by the rtl
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// property must hold on every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");
// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ----- rtl/sm4_pkg.sv -----
// sm4 shared types, constants and round functions
// no dependencies
package sm4_pkg;

  localparam int unsigned NumRounds = 32;
  localparam int unsigned RoundsLog = $clog2(NumRounds);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXPAND,
    ST_LOAD,
    ST_ROUND,
    ST_FINISH,
    ST_OUTPUT
  } sm4_state_t;

  localparam logic [2:0] CfgKeyHigh = 3'd0;
  localparam logic [2:0] CfgKeyLow  = 3'd1;
  localparam logic [2:0] CfgIvHigh  = 3'd2;
  localparam logic [2:0] CfgIvLow   = 3'd3;
  localparam logic [2:0] CfgDecrypt = 3'd4;
  localparam logic [2:0] CfgChain   = 3'd5;

  // controller to datapath commands
  typedef struct packed {
    logic key_init;
    logic key_step;
    logic load;
    logic round_step;
    logic finish;
  } sm4_cmd_t;

  localparam logic [127:0] Fk = 128'ha3b1bac6_56aa3350_677d9197_b27022dc;

  function automatic logic [7:0] sbox(input logic [7:0] a);
    logic [7:0] t [256];
    t = '{
      8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
      8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
      8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
      8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
      8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
      8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
      8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
      8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
      8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
      8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
      8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
      8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
      8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
      8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
      8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
      8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
    };
    return t[a];
  endfunction

  function automatic logic [31:0] subst(input logic [31:0] x);
    return {sbox(x[31:24]), sbox(x[23:16]), sbox(x[15:8]), sbox(x[7:0])};
  endfunction

  function automatic logic [31:0] rotl(input logic [31:0] x, input int unsigned n);
    return (x << n) | (x >> (32 - n));
  endfunction

  // constant ck word for key round i: byte j is (4i+j)*7 mod 256
  function automatic logic [31:0] ck_word(input logic [RoundsLog-1:0] i);
    logic [7:0] b0;
    b0 = 8'({i, 2'b00}) * 8'd7;
    return {b0, b0 + 8'd7, b0 + 8'd14, b0 + 8'd21};
  endfunction

endpackage

// ----- rtl/sm4_ctrl.sv -----
// sm4 controller state machine
// depends on sm4_pkg
module sm4_ctrl import sm4_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 out_free,
  input  logic                 keys_fresh,
  input  logic                 cnt_last,
  output logic                 in_take,
  output logic                 out_load,
  output sm4_cmd_t             cmd,
  output sm4_state_t           state
);
  sm4_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (in_valid) state_next = keys_fresh ? ST_LOAD : ST_EXPAND;
      ST_EXPAND: if (cnt_last) state_next = ST_LOAD;
      ST_LOAD:   state_next = ST_ROUND;
      ST_ROUND:  if (cnt_last) state_next = ST_FINISH;
      ST_FINISH: state_next = ST_OUTPUT;
      ST_OUTPUT: if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_take = 1'b0;
    out_load = 1'b0;
    case (state)
      ST_IDLE:   cmd.key_init = in_valid && !keys_fresh;
      ST_EXPAND: cmd.key_step = 1'b1;
      ST_LOAD: begin
        cmd.load = 1'b1;
        in_take = 1'b1;
      end
      ST_ROUND:  cmd.round_step = 1'b1;
      ST_FINISH: cmd.finish = 1'b1;
      ST_OUTPUT: out_load = out_free;
      default:   cmd = '0;
    endcase
  end
endmodule

// ----- rtl/sm4_datapath.sv -----
// sm4 datapath: key schedule, round key memory, round unit, cbc chain
// depends on sm4_pkg
module sm4_datapath import sm4_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  sm4_cmd_t             cmd,
  input  logic [63:0]          key_high,
  input  logic [63:0]          key_low,
  input  logic [63:0]          iv_high,
  input  logic [63:0]          iv_low,
  input  logic                 decrypt_mode,
  input  logic                 chain_enable,
  input  logic                 keys_stale,
  input  logic [127:0]         blk,
  input  logic                 restart,
  output logic                 keys_fresh,
  output logic                 cnt_last,
  output logic [127:0]         result
);
  logic [RoundsLog-1:0] cnt;
  logic [127:0] kreg;
  logic [127:0] x;
  logic [127:0] chain;
  logic [127:0] saved_in;
  logic         chain_loaded;
  logic [31:0]  rk_mem [NumRounds];
  logic [31:0]  rk;
  logic [31:0]  kb, nk, rb, nx;
  logic [RoundsLog-1:0] wr_addr, rd_addr;
  logic [127:0] cin;

  assign cnt_last = (cnt == '1);

  always_comb begin
    kb = subst(kreg[95:64] ^ kreg[63:32] ^ kreg[31:0] ^ ck_word(cnt));
    nk = kreg[127:96] ^ kb ^ rotl(kb, 13) ^ rotl(kb, 23);
    rb = subst(x[95:64] ^ x[63:32] ^ x[31:0] ^ rk);
    nx = x[127:96] ^ rb ^ rotl(rb, 2) ^ rotl(rb, 10) ^ rotl(rb, 18) ^ rotl(rb, 24);
    wr_addr = decrypt_mode ? ~cnt : cnt;
    // next round's key is fetched ahead through the registered memory read
    rd_addr = cmd.load ? '0 : cnt + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (cmd.key_step) rk_mem[wr_addr] <= nk;
    rk <= rk_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      keys_fresh <= 1'b0;
      chain_loaded <= 1'b0;
    end else begin
      if (keys_stale) keys_fresh <= 1'b0;
      if (cmd.key_init) cnt <= '0;
      if (cmd.key_step) begin
        cnt <= cnt + 1'b1;
        if (cnt_last) keys_fresh <= 1'b1;
      end
      if (cmd.load) begin
        cnt <= '0;
        chain_loaded <= 1'b1;
      end
      if (cmd.round_step) cnt <= cnt + 1'b1;
    end
  end

  always_comb begin
    cin = (restart || !chain_loaded) ? {iv_high, iv_low} : chain;
  end

  always_ff @(posedge clk) begin
    if (cmd.key_init) kreg <= {key_high, key_low} ^ Fk;
    if (cmd.key_step) kreg <= {kreg[95:0], nk};
    if (cmd.load) begin
      chain <= cin;
      saved_in <= blk;
      x <= (chain_enable && !decrypt_mode) ? blk ^ cin : blk;
    end
    if (cmd.round_step) x <= {x[95:0], nx};
    if (cmd.finish) begin
      if (!chain_enable) begin
        result <= {x[31:0], x[63:32], x[95:64], x[127:96]};
      end else if (!decrypt_mode) begin
        result <= {x[31:0], x[63:32], x[95:64], x[127:96]};
        chain <= {x[31:0], x[63:32], x[95:64], x[127:96]};
      end else begin
        result <= {x[31:0], x[63:32], x[95:64], x[127:96]} ^ chain;
        chain <= saved_in;
      end
    end
  end
endmodule

// ----- rtl/sm4_cbc_cipher.sv -----
// sm4 cbc cipher top level: config registers, output register, ctrl and datapath
// depends on sm4_pkg, sm4_ctrl, sm4_datapath, assert_macros.svh
//
// channel   dir  tdata                               tuser/tlast
// s_axis    in   block_high[63:0], block_low[127:64] tuser=restart, tlast=last_block
// m_axis    out  out_high[63:0], out_low[127:64]     tlast=out_last
// cfg       in   cfg_we, cfg_index[2:0], cfg_data[63:0]
//
// a block passes the idle cycle that sees tvalid, the load cycle that takes
// the beat, the round cycles, finish and output; m_axis_tvalid rises once the
// output state loads the output register; the first block after a key or
// mode write first expands the round keys into the round-key memory
// rst is synchronous and clears control state; config returns to its defaults
// s_axis_tready rises only in the load cycle; a stalled m_axis holds the block
`include "assert_macros.svh"
module sm4_cbc_cipher import sm4_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [127:0] s_axis_tdata,   // block_high, block_low
  input  logic         s_axis_tuser,   // restart
  input  logic         s_axis_tlast,   // last_block
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [127:0] m_axis_tdata,   // out_high, out_low
  output logic         m_axis_tlast,   // out_last
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [63:0]  cfg_data
);
  logic [63:0] key_high, key_low, iv_high, iv_low;
  logic        decrypt_mode, chain_enable;
  logic        keys_stale;
  logic        keys_fresh, cnt_last, in_take, out_load, out_free;
  logic        last_hold;
  logic [127:0] result;
  sm4_cmd_t    cmd;
  sm4_state_t  state;

  // config writes; key or mode writes force a new key expansion
  always_ff @(posedge clk) begin
    if (rst) begin
      key_high <= '0; key_low <= '0; iv_high <= '0; iv_low <= '0;
      decrypt_mode <= 1'b0; chain_enable <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        CfgKeyHigh: key_high <= cfg_data;
        CfgKeyLow:  key_low <= cfg_data;
        CfgIvHigh:  iv_high <= cfg_data;
        CfgIvLow:   iv_low <= cfg_data;
        CfgDecrypt: decrypt_mode <= cfg_data[0];
        CfgChain:   chain_enable <= cfg_data[0];
        default:    ;
      endcase
    end
  end

  assign keys_stale = cfg_we && (cfg_index == CfgKeyHigh || cfg_index == CfgKeyLow ||
                                 cfg_index == CfgDecrypt);

  assign s_axis_tready = in_take;
  assign out_free = !m_axis_tvalid || m_axis_tready;

  // last mark is captured with the block
  always_ff @(posedge clk) begin
    if (in_take) last_hold <= s_axis_tlast;
  end

  // output register; the next block may start while this one waits
  always_ff @(posedge clk) begin
    if (rst) m_axis_tvalid <= 1'b0;
    else if (out_load) m_axis_tvalid <= 1'b1;
    else if (m_axis_tready) m_axis_tvalid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_axis_tdata <= {result[63:0], result[127:64]};
      m_axis_tlast <= last_hold;
    end
  end

  sm4_ctrl u_ctrl (
    .clk, .rst,
    .in_valid(s_axis_tvalid),
    .out_free, .keys_fresh, .cnt_last,
    .in_take, .out_load, .cmd, .state
  );

  sm4_datapath u_dp (
    .clk, .rst, .cmd,
    .key_high, .key_low, .iv_high, .iv_low,
    .decrypt_mode, .chain_enable, .keys_stale,
    .blk({s_axis_tdata[63:0], s_axis_tdata[127:64]}),
    .restart(s_axis_tuser),
    .keys_fresh, .cnt_last,
    .result
  );

  `ASSERT_ALWAYS(a_ready_only_load, clk, rst, !s_axis_tready || state == ST_LOAD)
  `ASSERT_NEXT(a_load_starts_rounds, clk, rst, cmd.load, state == ST_ROUND)
  `ASSERT_NEXT(a_output_valid, clk, rst, out_load, m_axis_tvalid)
endmodule

// ----- dv/sm4_cbc_cipher_test.sv -----
// self-checking bench for sm4 cbc: directed vectors, backpressure, then random messages
// depends on sm4_pkg (register index codes) and the sm4_cbc_cipher rtl
module sm4_cbc_cipher_test;
  import sm4_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [63:0] hi;
    logic [63:0] lo;
    logic        last;
  } cipher_block_t;

  logic         clk;
  logic         rst;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [127:0] s_axis_tdata;   // block_high, block_low
  logic         s_axis_tuser;   // restart
  logic         s_axis_tlast;   // last_block
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [127:0] m_axis_tdata;   // out_high, out_low
  logic         m_axis_tlast;   // out_last
  logic         cfg_we;
  logic [2:0]   cfg_index;
  logic [63:0]  cfg_data;

  sm4_cbc_cipher u_top (.*);

  // predictor state: our own copy of registers, round keys and chain
  logic [63:0] key_hi_q, key_lo_q, iv_hi_q, iv_lo_q;
  logic        decrypt_q, chain_en_q;
  logic [31:0] pred_rk [32];
  bit          keys_valid;
  logic [63:0] chain_hi, chain_lo;
  bit          chain_valid;

  cipher_block_t expected_blocks [$];
  int unsigned   error_count;
  int unsigned   result_count;
  int unsigned   cycle_count;
  bit            hold_off;      // long receiver stall request
  int unsigned   hold_cycles;

  localparam int unsigned CycleLimit = 600000;

  // sbox as a local table so the predictor does not lean on the package
  function automatic logic [7:0] sbox_byte(input logic [7:0] a);
    logic [7:0] t [256];
    t = '{
      8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
      8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
      8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
      8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
      8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
      8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
      8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
      8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
      8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
      8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
      8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
      8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
      8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
      8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
      8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
      8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
    };
    return t[a];
  endfunction

  function automatic logic [31:0] tau(input logic [31:0] x);
    return {sbox_byte(x[31:24]), sbox_byte(x[23:16]), sbox_byte(x[15:8]), sbox_byte(x[7:0])};
  endfunction

  function automatic logic [31:0] rol32(input logic [31:0] x, input int n);
    return (x << n) | (x >> (32 - n));
  endfunction

  // standard key schedule; round keys stored reversed for decryption
  task automatic expand_round_keys();
    logic [31:0] k [4];
    logic [31:0] sched [32];
    logic [31:0] b, ck;
    logic [7:0]  cb;
    k[0] = key_hi_q[63:32] ^ 32'ha3b1bac6;
    k[1] = key_hi_q[31:0]  ^ 32'h56aa3350;
    k[2] = key_lo_q[63:32] ^ 32'h677d9197;
    k[3] = key_lo_q[31:0]  ^ 32'hb27022dc;
    for (int i = 0; i < 32; i++) begin
      for (int j = 0; j < 4; j++) begin
        cb = 8'((4 * i + j) * 7);
        ck = {ck[23:0], cb};
      end
      b = tau(k[1] ^ k[2] ^ k[3] ^ ck);
      sched[i] = k[0] ^ b ^ rol32(b, 13) ^ rol32(b, 23);
      k[0] = k[1]; k[1] = k[2]; k[2] = k[3]; k[3] = sched[i];
    end
    for (int i = 0; i < 32; i++)
      pred_rk[i] = decrypt_q ? sched[31 - i] : sched[i];
    keys_valid = 1;
  endtask

  function automatic logic [127:0] sm4_rounds(input logic [127:0] blk);
    logic [31:0] x [4];
    logic [31:0] b, nx;
    x[0] = blk[127:96]; x[1] = blk[95:64]; x[2] = blk[63:32]; x[3] = blk[31:0];
    for (int i = 0; i < 32; i++) begin
      b = tau(x[1] ^ x[2] ^ x[3] ^ pred_rk[i]);
      nx = x[0] ^ b ^ rol32(b, 2) ^ rol32(b, 10) ^ rol32(b, 18) ^ rol32(b, 24);
      x[0] = x[1]; x[1] = x[2]; x[2] = x[3]; x[3] = nx;
    end
    // output words reversed
    return {x[3], x[2], x[1], x[0]};
  endfunction

  // expected ciphertext or plaintext for one accepted block
  task automatic predict_block(input logic [63:0] hi, input logic [63:0] lo,
                               input logic restart, input logic last);
    logic [127:0] r;
    cipher_block_t e;
    if (!keys_valid) expand_round_keys();
    if (restart || !chain_valid) begin
      chain_hi = iv_hi_q; chain_lo = iv_lo_q; chain_valid = 1;
    end
    if (!chain_en_q) begin
      r = sm4_rounds({hi, lo});
    end else if (!decrypt_q) begin
      r = sm4_rounds({hi ^ chain_hi, lo ^ chain_lo});
      {chain_hi, chain_lo} = r;
    end else begin
      r = sm4_rounds({hi, lo}) ^ {chain_hi, chain_lo};
      chain_hi = hi; chain_lo = lo;
    end
    e.hi = r[127:64]; e.lo = r[63:0]; e.last = last;
    expected_blocks.push_back(e);
  endtask

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("[sm4_cbc_cipher] ERROR");
      $finish;
    end
  end

  // receiver: random stalls per beat, plus a long hold-off on request
  initial begin
    int unsigned gap;
    m_axis_tready = 0;
    @(negedge clk);
    forever begin
      if (hold_off) begin
        m_axis_tready <= 0;
        for (int i = 0; i < hold_cycles; i++) @(negedge clk);
        hold_off = 0;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
      if (gap != 0) begin
        m_axis_tready <= 0;
        repeat (gap) @(negedge clk);
      end
      m_axis_tready <= 1;
      @(posedge clk);
      while (!m_axis_tvalid) @(posedge clk);
      @(negedge clk);
    end
  end

  // result checker: compares every beat with the oldest expectation
  always @(posedge clk) begin
    cipher_block_t e;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      result_count++;
      if (expected_blocks.size() == 0) begin
        $error("unexpected result beat %h", m_axis_tdata);
        error_count++;
      end else begin
        e = expected_blocks.pop_front();
        if (m_axis_tdata[63:0] !== e.hi) begin
          $error("out_high expected %h got %h", e.hi, m_axis_tdata[63:0]);
          error_count++;
        end
        if (m_axis_tdata[127:64] !== e.lo) begin
          $error("out_low expected %h got %h", e.lo, m_axis_tdata[127:64]);
          error_count++;
        end
        if (m_axis_tlast !== e.last) begin
          $error("out_last expected %b got %b", e.last, m_axis_tlast);
          error_count++;
        end
      end
    end
  end

  // one beat into the block, random pre-gap; prediction at acceptance
  // tvalid stays up after the beat until the next send drops or replaces it, or wait_idle drops it
  task automatic send_block(input logic [63:0] hi, input logic [63:0] lo,
                            input logic restart, input logic last, input bit no_gap = 0);
    int unsigned gap;
    gap = no_gap ? 0 : (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6));
    if (gap != 0) begin
      s_axis_tvalid <= 0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata  <= {lo, hi};
    s_axis_tuser  <= restart;
    s_axis_tlast  <= last;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    predict_block(hi, lo, restart, last);
    @(negedge clk);
  endtask

  // block must be idle: drain, then pad for a possible in-flight key expansion
  task automatic wait_idle();
    s_axis_tvalid <= 0;
    while (expected_blocks.size() != 0) @(negedge clk);
    repeat (80) @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
    cfg_we <= 1; cfg_index <= idx; cfg_data <= val;
    @(negedge clk);
    cfg_we <= 0;
    @(negedge clk);
    case (idx)
      CfgKeyHigh: begin key_hi_q = val; keys_valid = 0; end
      CfgKeyLow:  begin key_lo_q = val; keys_valid = 0; end
      CfgIvHigh:  iv_hi_q = val;
      CfgIvLow:   iv_lo_q = val;
      CfgDecrypt: begin decrypt_q = val[0]; keys_valid = 0; end
      CfgChain:   chain_en_q = val[0];
      default: ;
    endcase
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // standard test vector, extremes of the block, restart and last flags
  task automatic test_directed();
    write_reg(CfgKeyHigh, 64'h0123456789abcdef);
    write_reg(CfgKeyLow,  64'hfedcba9876543210);
    write_reg(CfgChain, 64'd0);
    send_block(64'h0123456789abcdef, 64'hfedcba9876543210, 0, 1);
    send_block(64'h0, 64'h0, 0, 0);
    send_block('1, '1, 1, 1);
    wait_idle();
    // cbc encrypt, first block without restart continues from the stored chain
    write_reg(CfgIvHigh, 64'h0001020304050607);
    write_reg(CfgIvLow,  64'h08090a0b0c0d0e0f);
    write_reg(CfgChain, 64'd1);
    send_block(64'h0, 64'h0, 0, 0);
    send_block('1, '1, 0, 0);
    // iv change mid-message only counts at the next restart
    wait_idle();
    write_reg(CfgIvHigh, '1);
    send_block(64'haaaa5555aaaa5555, 64'h5555aaaa5555aaaa, 0, 1);
    send_block(64'h1, 64'h8000000000000000, 1, 0);
    send_block(64'h0, 64'h0, 0, 1);
    wait_idle();
    // cbc decrypt, and out-of-range indices that must be ignored
    write_reg(CfgDecrypt, 64'd1);
    write_reg(3'd6, '1);
    write_reg(3'd7, '1);
    send_block('1, 64'h0, 1, 0);
    send_block(64'h0, '1, 0, 1);
    wait_idle();
    write_reg(CfgChain, 64'd0);
    send_block(64'h123, 64'h456, 1, 1);
    wait_idle();
  endtask

  // random messages under random settings
  task automatic test_random_messages(input int unsigned n_blocks);
    int unsigned sent, msg_len;
    sent = 0;
    while (sent < n_blocks) begin
      wait_idle();
      if ($urandom_range(0, 1)) write_reg(CfgKeyHigh, ($urandom_range(0, 7) == 0) ? '1 : rand64());
      if ($urandom_range(0, 1)) write_reg(CfgKeyLow, ($urandom_range(0, 7) == 0) ? '0 : rand64());
      write_reg(CfgIvHigh, rand64());
      write_reg(CfgIvLow, rand64());
      if ($urandom_range(0, 2) == 0) write_reg(CfgDecrypt, 64'($urandom_range(0, 1)));
      write_reg(CfgChain, ($urandom_range(0, 4) == 0) ? 64'd0 : 64'd1);
      for (int m = 0; m < 6; m++) begin
        msg_len = $urandom_range(1, 12);
        for (int i = 0; i < msg_len; i++) begin
          // mostly well-formed messages: restart on first, last on final
          send_block(rand64(), rand64(),
                     (i == 0) ? ($urandom_range(0, 7) != 0) : ($urandom_range(0, 15) == 0),
                     (i == msg_len - 1) ? ($urandom_range(0, 7) != 0)
                                        : ($urandom_range(0, 15) == 0));
          sent++;
        end
      end
    end
    wait_idle();
  endtask

  // receiver holds off long while we keep offering, then sender drains fully
  task automatic test_backpressure();
    hold_cycles = 400;
    hold_off = 1;
    for (int i = 0; i < 12; i++) send_block(rand64(), rand64(), i == 0, i == 11, 1);
    wait_idle();
  endtask

  initial begin
    rst = 1;
    s_axis_tvalid = 0; s_axis_tdata = '0; s_axis_tuser = 0; s_axis_tlast = 0;
    cfg_we = 0; cfg_index = '0; cfg_data = '0;
    key_hi_q = 0; key_lo_q = 0; iv_hi_q = 0; iv_lo_q = 0;
    decrypt_q = 0; chain_en_q = 1; keys_valid = 0; chain_valid = 0;
    chain_hi = 0; chain_lo = 0;
    error_count = 0; result_count = 0; cycle_count = 0; hold_off = 0; hold_cycles = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 0;
    test_directed();
    test_backpressure();
    test_random_messages(1720);
    repeat (100) @(negedge clk);
    $display("covered %0d result beats: ecb and cbc, encrypt and decrypt, key and iv changes,",
             result_count);
    $display("restart and last flags, and a long output stall");
    if (error_count == 0 && expected_blocks.size() == 0) begin
      $display("[sm4_cbc_cipher] OK");
    end else begin
      $display("[sm4_cbc_cipher] ERROR");
    end
    $finish;
  end
endmodule
